@@ sv/ibhq_pkg.sv @@
`default_nettype none

package ibhq_pkg;

  // heap geometry and field widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned ID_W     = 6;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = SLOT_W + 1;
  localparam int unsigned ENTRY_W  = ID_W + KEY_W;

  // operation codes
  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_CHANGE  = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_BAD_SLOT = 2'd3
  } status_e;

  // one heap entry as stored in memory
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  // strict priority compare: true when key a beats key b
  function automatic logic outranks(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b,
                                    input logic             larger);
    return larger ? (a > b) : (a < b);
  endfunction

endpackage

`default_nettype wire

@@ sv/ibhq_ram.sv @@
`default_nettype none

module ibhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

@@ sv/indexed_binary_heap_queue.sv @@
// Indexed binary-heap priority queue of (id, key) entries, up to 64 entries.
// Input channel (in_valid_i / in_stall_o) carries one operation item:
// mode_i selects insert, extract top or change key at slot_i. An item is taken
// at a clock edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i) returns exactly one result item
// per operation: entry id and key, settled slot, status and occupancy.
// Config channel (cfg_valid_i / cfg_ready_o) writes larger_first; write it
// only while no operation is in flight.
// Rejected or ignored operations go straight to the result stage; otherwise
// each heap level walked is a registered memory read, then a compare and
// write back. One operation is worked at a time and the next item is taken
// only after the result is presented; the heap memory's read-compare-write
// loop is not overlapped between operations.
// A finished result sits in an output register, so the next item is taken
// while it waits; if the receiver stalls and a second result is done, the
// block holds it and stalls its input until the register frees.
// Reset empties the queue and sets larger_first to 1; the memory contents
// need no clearing since only slots below the occupancy are ever used.
`default_nettype none

module indexed_binary_heap_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // operation items
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    mode_i,
  input  wire logic [ibhq_pkg::ID_W-1:0]     item_id_i,
  input  wire logic [ibhq_pkg::KEY_W-1:0]    key_i,
  input  wire logic [ibhq_pkg::SLOT_W-1:0]   slot_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [ibhq_pkg::ID_W-1:0]     out_id_o,
  output logic      [ibhq_pkg::KEY_W-1:0]    out_key_o,
  output logic      [ibhq_pkg::SLOT_W-1:0]   final_slot_o,
  output logic      [1:0]                    status_o,
  output logic      [ibhq_pkg::CNT_W-1:0]    occupancy_o,
  // configuration
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_larger_first_i
);

  localparam int unsigned SLOT_W = ibhq_pkg::SLOT_W;
  localparam int unsigned CNT_W  = ibhq_pkg::CNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EX_RD,
    S_EX_LD,
    S_CH_RD,
    S_CH_LD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  ibhq_pkg::mode_e             mode_q, mode_d;
  logic [ibhq_pkg::ID_W-1:0]   cur_id_q, cur_id_d;
  logic [ibhq_pkg::KEY_W-1:0]  cur_key_q, cur_key_d;
  logic [SLOT_W-1:0]           hole_q, hole_d;
  logic                        rose_q, rose_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        larger_q, larger_d;
  logic [ibhq_pkg::ID_W-1:0]   res_id_q, res_id_d;
  logic [ibhq_pkg::KEY_W-1:0]  res_key_q, res_key_d;
  logic [SLOT_W-1:0]           res_slot_q, res_slot_d;
  ibhq_pkg::status_e           res_status_q, res_status_d;
  logic                        out_valid_q, out_valid_d;
  logic [ibhq_pkg::ID_W-1:0]   out_id_q, out_id_d;
  logic [ibhq_pkg::KEY_W-1:0]  out_key_q, out_key_d;
  logic [SLOT_W-1:0]           out_slot_q, out_slot_d;
  logic [1:0]                  out_status_q, out_status_d;
  logic [CNT_W-1:0]            out_occ_q, out_occ_d;

  // heap memory ports
  logic                          ram_we;
  logic [SLOT_W-1:0]             ram_waddr;
  ibhq_pkg::entry_t              ram_wdata;
  logic [SLOT_W-1:0]             ram_raddr_a, ram_raddr_b;
  logic [ibhq_pkg::ENTRY_W-1:0]  ram_rdata_a, ram_rdata_b;
  ibhq_pkg::entry_t              rd_a, rd_b;

  // tree navigation
  logic [SLOT_W-1:0]   parent_w;
  logic [SLOT_W:0]     left_w;
  logic [SLOT_W+1:0]   right_w;
  logic [CNT_W-1:0]    count_m1_w;
  logic                has_right_w;
  logic                pick_right_w;
  ibhq_pkg::entry_t    best_w;
  logic [SLOT_W-1:0]   best_slot_w;
  logic                in_accept_w;

  assign rd_a        = ibhq_pkg::entry_t'(ram_rdata_a);
  assign rd_b        = ibhq_pkg::entry_t'(ram_rdata_b);
  assign parent_w    = (hole_q - SLOT_W'(1)) >> 1;
  assign left_w      = {hole_q, 1'b1};
  assign right_w     = {1'b0, left_w} + (SLOT_W + 2)'(1);
  assign count_m1_w  = count_q - CNT_W'(1);
  assign has_right_w = right_w < {1'b0, count_q};
  assign pick_right_w = has_right_w && !ibhq_pkg::outranks(rd_a.key, rd_b.key, larger_q);
  assign best_w      = pick_right_w ? rd_b : rd_a;
  assign best_slot_w = pick_right_w ? right_w[SLOT_W-1:0] : left_w[SLOT_W-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept_w = in_valid_i && (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);

  ibhq_ram #(
    .WIDTH (ibhq_pkg::ENTRY_W),
    .DEPTH (ibhq_pkg::CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_b_o (ram_rdata_b)
  );

  // sequencer: sift walks and result assembly
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    cur_id_d     = cur_id_q;
    cur_key_d    = cur_key_q;
    hole_d       = hole_q;
    rose_d       = rose_q;
    count_d      = count_q;
    larger_d     = larger_q;
    res_id_d     = res_id_q;
    res_key_d    = res_key_q;
    res_slot_d   = res_slot_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_id_d     = out_id_q;
    out_key_d    = out_key_q;
    out_slot_d   = out_slot_q;
    out_status_d = out_status_q;
    out_occ_d    = out_occ_q;
    ram_we       = 1'b0;
    ram_waddr    = hole_q;
    ram_wdata    = '{id: cur_id_q, key: cur_key_q};
    ram_raddr_a  = '0;
    ram_raddr_b  = '0;

    // output register drains
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    // configuration write
    if (cfg_valid_i && cfg_ready_o) begin
      larger_d = cfg_larger_first_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept_w) begin
          mode_d       = ibhq_pkg::mode_e'(mode_i);
          rose_d       = 1'b0;
          res_id_d     = '0;
          res_key_d    = '0;
          res_slot_d   = '0;
          res_status_d = ibhq_pkg::STATUS_OK;
          case (ibhq_pkg::mode_e'(mode_i))
            ibhq_pkg::MODE_INSERT: begin
              res_id_d  = item_id_i;
              res_key_d = key_i;
              cur_id_d  = item_id_i;
              cur_key_d = key_i;
              if (count_q == CNT_W'(ibhq_pkg::CAPACITY)) begin
                res_status_d = ibhq_pkg::STATUS_FULL;
                state_d      = S_DONE;
              end else begin
                count_d = count_q + CNT_W'(1);
                hole_d  = count_q[SLOT_W-1:0];
                state_d = (count_q == '0) ? S_PLACE : S_UP_RD;
              end
            end
            ibhq_pkg::MODE_EXTRACT: begin
              if (count_q == '0) begin
                res_status_d = ibhq_pkg::STATUS_EMPTY;
                state_d      = S_DONE;
              end else begin
                state_d = S_EX_RD;
              end
            end
            ibhq_pkg::MODE_CHANGE: begin
              if ({1'b0, slot_i} >= count_q) begin
                res_status_d = ibhq_pkg::STATUS_BAD_SLOT;
                state_d      = S_DONE;
              end else begin
                hole_d    = slot_i;
                cur_key_d = key_i;
                state_d   = S_CH_RD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      // read root and last entry together
      S_EX_RD: begin
        ram_raddr_a = '0;
        ram_raddr_b = count_m1_w[SLOT_W-1:0];
        count_d     = count_m1_w;
        state_d     = S_EX_LD;
      end
      S_EX_LD: begin
        res_id_d  = rd_a.id;
        res_key_d = rd_a.key;
        cur_id_d  = rd_b.id;
        cur_key_d = rd_b.key;
        hole_d    = '0;
        state_d   = (count_q == '0) ? S_DONE : S_DN_RD;
      end
      // fetch the id at the changed slot
      S_CH_RD: begin
        ram_raddr_a = hole_q;
        state_d     = S_CH_LD;
      end
      S_CH_LD: begin
        cur_id_d  = rd_a.id;
        res_id_d  = rd_a.id;
        res_key_d = cur_key_q;
        state_d   = (hole_q == '0) ? S_DN_RD : S_UP_RD;
      end
      // sift up one level
      S_UP_RD: begin
        ram_raddr_a = parent_w;
        state_d     = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (ibhq_pkg::outranks(cur_key_q, rd_a.key, larger_q)) begin
          ram_we    = 1'b1;
          ram_wdata = rd_a;
          hole_d    = parent_w;
          rose_d    = 1'b1;
          state_d   = (parent_w == '0) ? S_PLACE : S_UP_RD;
        end else if (mode_q == ibhq_pkg::MODE_CHANGE && !rose_q) begin
          state_d = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      // sift down one level
      S_DN_RD: begin
        if (left_w >= count_q) begin
          state_d = S_PLACE;
        end else begin
          ram_raddr_a = left_w[SLOT_W-1:0];
          ram_raddr_b = right_w[SLOT_W-1:0];
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (ibhq_pkg::outranks(best_w.key, cur_key_q, larger_q)) begin
          ram_we    = 1'b1;
          ram_wdata = best_w;
          hole_d    = best_slot_w;
          state_d   = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      // settle the moving entry in the hole
      S_PLACE: begin
        ram_we = 1'b1;
        if (mode_q != ibhq_pkg::MODE_EXTRACT) begin
          res_slot_d = hole_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_id_d     = res_id_q;
          out_key_d    = res_key_q;
          out_slot_d   = res_slot_q;
          out_status_d = res_status_q;
          out_occ_d    = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      larger_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      larger_q    <= larger_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    cur_id_q     <= cur_id_d;
    cur_key_q    <= cur_key_d;
    hole_q       <= hole_d;
    rose_q       <= rose_d;
    res_id_q     <= res_id_d;
    res_key_q    <= res_key_d;
    res_slot_q   <= res_slot_d;
    res_status_q <= res_status_d;
    out_id_q     <= out_id_d;
    out_key_q    <= out_key_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_id_o     = out_id_q;
  assign out_key_o    = out_key_q;
  assign final_slot_o = out_slot_q;
  assign status_o     = out_status_q;
  assign occupancy_o  = out_occ_q;

`ifndef SYNTHESIS
  // occupancy never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(ibhq_pkg::CAPACITY))
    else $error("heap count exceeds capacity");

  // heap memory is written only from compare or place steps
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_UP_CMP || state_q == S_DN_CMP || state_q == S_PLACE))
    else $error("heap write outside a sift step");

  // the hole lies inside the live heap in the sift read and place steps
  a_hole_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP_RD || state_q == S_DN_RD || state_q == S_PLACE)
      |-> ({1'b0, hole_q} < count_q))
    else $error("sift hole outside live heap");

  // a finished item reaches the output register next cycle
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished item not presented");

  // every accepted item leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_w |=> (state_q != S_IDLE))
    else $error("accepted item dropped");
`endif

endmodule

`default_nettype wire
